// File: hdl/xifd_pkg.sv
package xifd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_OPC   = 3'd1,
    PH_MAP2  = 3'd2,
    PH_MAP3  = 3'd3,
    PH_MODRM = 3'd4,
    PH_SIB   = 3'd5,
    PH_DISP  = 3'd6,
    PH_IMM   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_OPC = 2'd1,
    ST_BAD_GRP = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_MODRM = 2'd1,
    KIND_GROUP = 2'd2
  } kind_e;

  localparam logic [7:0] EscByte = 8'h0f;
  localparam logic [7:0] Esc3A   = 8'hae;
  localparam logic [7:0] Esc3B   = 8'hf3;
  localparam logic [7:0] RexMask = 8'hf0;
  localparam logic [7:0] RexVal  = 8'h40;
  localparam logic [7:0] BakeMsk = 8'hf8;

  typedef struct packed {
    logic       hit;
    logic [5:0] id;
    logic [2:0] form;
    kind_e      kind;
    logic [3:0] imm;
  } row_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] id;
    logic [3:0] imm;
  } grow_t;

  // one decoded instruction as handed from the front part to the back part
  typedef struct packed {
    logic        last;
    logic        emit;
    status_e     status;
    logic [3:0]  length;
    logic [4:0]  rex;
    logic [1:0]  opcode_map;
    logic [7:0]  opcode;
    logic [5:0]  mnemonic_id;
    logic [2:0]  operand_form;
    logic [7:0]  modrm;
    logic [7:0]  sib;
    logic [31:0] displacement;
    logic [63:0] immediate;
  } result_t;

  function automatic row_t mk(input logic [5:0] id, input logic [2:0] form, input kind_e k,
                              input logic [3:0] imm);
    row_t r;
    r.hit = 1'b1; r.id = id; r.form = form; r.kind = k; r.imm = imm;
    return r;
  endfunction

  function automatic row_t find_row(input logic [1:0] map, input logic [7:0] b);
    row_t r;
    r = '0;
    case (map)
      2'd0: begin
        case (b)
          8'h01: r = mk(0, 2, KIND_MODRM, 0);
          8'h03: r = mk(0, 3, KIND_MODRM, 0);
          8'h21: r = mk(1, 2, KIND_MODRM, 0);
          8'h23: r = mk(1, 3, KIND_MODRM, 0);
          8'he8: r = mk(2, 0, KIND_NONE, 4);
          8'h38: r = mk(4, 3, KIND_MODRM, 0);
          8'h39: r = mk(5, 3, KIND_MODRM, 0);
          8'h3a: r = mk(4, 2, KIND_MODRM, 0);
          8'h3b: r = mk(5, 2, KIND_MODRM, 0);
          8'hc8: r = mk(6, 0, KIND_NONE, 3);
          8'h69: r = mk(7, 3, KIND_MODRM, 4);
          8'he9: r = mk(8, 0, KIND_NONE, 4);
          8'h8d: r = mk(9, 3, KIND_MODRM, 0);
          8'h89: r = mk(10, 2, KIND_MODRM, 0);
          8'h8b: r = mk(10, 3, KIND_MODRM, 0);
          8'h09: r = mk(11, 2, KIND_MODRM, 0);
          8'h0a: r = mk(11, 3, KIND_MODRM, 0);
          8'h8f: r = mk(12, 4, KIND_MODRM, 0);
          8'h68: r = mk(13, 0, KIND_NONE, 4);
          8'h29: r = mk(14, 2, KIND_MODRM, 0);
          8'h2b: r = mk(14, 3, KIND_MODRM, 0);
          8'h85: r = mk(15, 2, KIND_MODRM, 0);
          8'h87: r = mk(16, 2, KIND_MODRM, 0);
          8'h31: r = mk(17, 2, KIND_MODRM, 0);
          8'h33: r = mk(17, 3, KIND_MODRM, 0);
          8'hcd: r = mk(18, 0, KIND_NONE, 1);
          8'hcc: r = mk(19, 0, KIND_NONE, 0);
          8'h9f: r = mk(20, 0, KIND_NONE, 0);
          8'hc9: r = mk(21, 0, KIND_NONE, 0);
          8'h90: r = mk(22, 0, KIND_NONE, 0);
          8'h9c: r = mk(23, 0, KIND_NONE, 0);
          8'hc3: r = mk(24, 0, KIND_NONE, 0);
          8'hcb: r = mk(25, 0, KIND_NONE, 0);
          8'h9e: r = mk(26, 0, KIND_NONE, 0);
          8'hf9: r = mk(27, 0, KIND_NONE, 0);
          8'hfd: r = mk(28, 0, KIND_NONE, 0);
          8'h80, 8'h81, 8'hc7, 8'hf7, 8'hff: r = mk(0, 0, KIND_GROUP, 0);
          default: begin
            case (b & BakeMsk)
              8'h40: r = mk(3, 1, KIND_MODRM, 0);
              8'hb8: r = mk(10, 1, KIND_NONE, 8);
              8'h58: r = mk(12, 1, KIND_NONE, 0);
              8'h50: r = mk(13, 1, KIND_NONE, 0);
              default: r = '0;
            endcase
          end
        endcase
      end
      2'd1: begin
        case (b)
          8'haf: r = mk(7, 3, KIND_MODRM, 0);
          8'ha2: r = mk(31, 0, KIND_NONE, 0);
          8'h90: r = mk(32, 0, KIND_NONE, 0);
          default: begin
            case (b & BakeMsk)
              8'hc8: r = mk(29, 1, KIND_NONE, 0);
              8'h80: r = mk(30, 0, KIND_NONE, 4);
              default: r = '0;
            endcase
          end
        endcase
      end
      2'd2: begin
        case (b)
          8'hbd: r = mk(33, 3, KIND_MODRM, 0);
          8'hb8: r = mk(34, 3, KIND_MODRM, 0);
          8'he8: r = mk(35, 0, KIND_NONE, 0);
          8'hf0: r = mk(36, 0, KIND_NONE, 0);
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic grow_t gmk(input logic [5:0] id, input logic [3:0] imm);
    grow_t g;
    g.hit = 1'b1; g.id = id; g.imm = imm;
    return g;
  endfunction

  function automatic grow_t find_grow(input logic [7:0] op, input logic [2:0] reg_f);
    grow_t g;
    g = '0;
    case ({op, reg_f})
      {8'h81, 3'd0}: g = gmk(0, 4);
      {8'h81, 3'd4}: g = gmk(1, 4);
      {8'h80, 3'd7}: g = gmk(4, 1);
      {8'h81, 3'd7}: g = gmk(4, 4);
      {8'hff, 3'd2}: g = gmk(2, 0);
      {8'hff, 3'd1}: g = gmk(37, 0);
      {8'hf7, 3'd6}: g = gmk(38, 0);
      {8'hf7, 3'd7}: g = gmk(39, 0);
      {8'hff, 3'd0}: g = gmk(40, 0);
      {8'hff, 3'd4}: g = gmk(8, 0);
      {8'hff, 3'd3}: g = gmk(41, 0);
      {8'hc7, 3'd0}: g = gmk(10, 4);
      {8'hf7, 3'd4}: g = gmk(42, 0);
      {8'hf7, 3'd3}: g = gmk(43, 0);
      {8'hf7, 3'd2}: g = gmk(44, 0);
      {8'h81, 3'd1}: g = gmk(11, 4);
      {8'hff, 3'd6}: g = gmk(13, 0);
      {8'h81, 3'd5}: g = gmk(14, 4);
      {8'hf7, 3'd0}: g = gmk(15, 4);
      {8'h81, 3'd6}: g = gmk(17, 4);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: hdl/xifd_front.sv
module xifd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          byte_i,
  output logic                emit_o,
  output xifd_pkg::result_t   res_o
);

  xifd_pkg::phase_e phase_q, phase_d;
  logic [4:0]  rex_q, rex_d;
  logic [7:0]  opc_q, opc_d;
  logic [1:0]  map_q, map_d;
  logic [5:0]  id_q, id_d;
  logic [2:0]  form_q, form_d;
  xifd_pkg::kind_e kind_q, kind_d;
  logic [3:0]  imm_sz_q, imm_sz_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [7:0]  sib_q, sib_d;
  logic [31:0] disp_q, disp_d;
  logic [63:0] imm_q, imm_d;
  logic [2:0]  dsz_q, dsz_d;
  logic [3:0]  left_q, left_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [2:0]  pos_q, pos_d;

  xifd_pkg::row_t  row;
  xifd_pkg::grow_t grow;
  logic [3:0]  cnt_n;
  logic [1:0]  lmap;
  logic        take_opc;
  logic        go_disp, go_imm, emit_ok, emit_err;
  xifd_pkg::status_e err_st;
  logic [7:0]  err_opc;
  logic [7:0]  m_v, s_v;
  logic [3:0]  isz;
  logic [2:0]  dsz;
  logic [31:0] disp_f;
  logic [63:0] imm_f;

  assign cnt_n = cnt_q + 4'd1;

  always_comb begin
    lmap = 2'd0;
    case (phase_q)
      xifd_pkg::PH_MAP2: lmap = 2'd1;
      xifd_pkg::PH_MAP3: lmap = 2'd2;
      default: lmap = 2'd0;
    endcase
  end

  assign row  = xifd_pkg::find_row(lmap, byte_i);
  assign grow = xifd_pkg::find_grow(opc_q, byte_i[5:3]);

  always_comb begin
    phase_d = phase_q; rex_d = rex_q; opc_d = opc_q; map_d = map_q; id_d = id_q;
    form_d = form_q; kind_d = kind_q; imm_sz_d = imm_sz_q; modrm_d = modrm_q;
    sib_d = sib_q; disp_d = disp_q; imm_d = imm_q; dsz_d = dsz_q; left_d = left_q;
    cnt_d = cnt_q; pos_d = pos_q;
    take_opc = 1'b0; go_disp = 1'b0; go_imm = 1'b0; emit_ok = 1'b0; emit_err = 1'b0;
    err_st = xifd_pkg::ST_BAD_OPC; err_opc = byte_i;
    m_v = modrm_q; s_v = sib_q; isz = imm_sz_q; dsz = 3'd0;
    if (valid_i) begin
      cnt_d = cnt_n;
      case (phase_q)
        xifd_pkg::PH_FIRST, xifd_pkg::PH_OPC: begin
          if (phase_q == xifd_pkg::PH_FIRST &&
              (byte_i & xifd_pkg::RexMask) == xifd_pkg::RexVal) begin
            rex_d = {1'b1, byte_i[3:0]};
            phase_d = xifd_pkg::PH_OPC;
          end else if (byte_i == xifd_pkg::EscByte) begin
            map_d = 2'd1;
            phase_d = xifd_pkg::PH_MAP2;
          end else begin
            take_opc = 1'b1;
          end
        end
        xifd_pkg::PH_MAP2: begin
          if (byte_i == xifd_pkg::Esc3A || byte_i == xifd_pkg::Esc3B) begin
            map_d = 2'd2;
            phase_d = xifd_pkg::PH_MAP3;
          end else begin
            take_opc = 1'b1;
          end
        end
        xifd_pkg::PH_MAP3: take_opc = 1'b1;
        xifd_pkg::PH_MODRM: begin
          modrm_d = byte_i;
          m_v = byte_i;
          if (kind_q == xifd_pkg::KIND_GROUP) begin
            if (!grow.hit) begin
              emit_err = 1'b1;
              err_st = xifd_pkg::ST_BAD_GRP;
              err_opc = opc_q;
            end else begin
              id_d = grow.id; form_d = 3'd4; kind_d = xifd_pkg::KIND_MODRM;
              imm_sz_d = grow.imm; isz = grow.imm;
            end
          end
          if (!emit_err) begin
            if (byte_i[7:6] != 2'd3 && byte_i[2:0] == 3'd4) phase_d = xifd_pkg::PH_SIB;
            else go_disp = 1'b1;
          end
        end
        xifd_pkg::PH_SIB: begin
          sib_d = byte_i;
          s_v = byte_i;
          go_disp = 1'b1;
        end
        xifd_pkg::PH_DISP: begin
          disp_d = disp_q | ({24'd0, byte_i} << {pos_q[1:0], 3'd0});
          pos_d = pos_q + 3'd1;
          left_d = left_q - 4'd1;
          if (left_q == 4'd1) go_imm = 1'b1;
        end
        xifd_pkg::PH_IMM: begin
          imm_d = imm_q | ({56'd0, byte_i} << {pos_q, 3'd0});
          pos_d = pos_q + 3'd1;
          left_d = left_q - 4'd1;
          if (left_q == 4'd1) emit_ok = 1'b1;
        end
        default: phase_d = xifd_pkg::PH_FIRST;
      endcase

      if (take_opc) begin
        if (!row.hit) begin
          emit_err = 1'b1;
        end else begin
          opc_d = byte_i; id_d = row.id; form_d = row.form; kind_d = row.kind;
          imm_sz_d = row.imm; isz = row.imm;
          if (row.kind != xifd_pkg::KIND_NONE) phase_d = xifd_pkg::PH_MODRM;
          else go_imm = 1'b1;
        end
      end

      if (isz == 4'd8 && !rex_q[3]) isz = 4'd4;

      if (go_disp) begin
        if (m_v[7:6] == 2'd1) dsz = 3'd1;
        else if (m_v[7:6] == 2'd2) dsz = 3'd4;
        else if (m_v[7:6] == 2'd0 &&
                 (m_v[2:0] == 3'd5 || (m_v[2:0] == 3'd4 && s_v[2:0] == 3'd5))) dsz = 3'd4;
        dsz_d = dsz;
        if (dsz != 3'd0) begin
          phase_d = xifd_pkg::PH_DISP; left_d = {1'b0, dsz}; pos_d = 3'd0;
        end else begin
          go_imm = 1'b1;
        end
      end
      if (go_imm) begin
        if (isz != 4'd0) begin
          phase_d = xifd_pkg::PH_IMM; left_d = isz; pos_d = 3'd0; imm_sz_d = isz;
        end else begin
          emit_ok = 1'b1;
        end
      end
    end
  end

  always_comb begin
    disp_f = (phase_q == xifd_pkg::PH_DISP) ? disp_d : disp_q;
    if (dsz_q == 3'd1 && disp_f[7]) disp_f[31:8] = '1;
    imm_f = imm_d;
    if (imm_sz_d == 4'd4 && imm_f[31]) imm_f[63:32] = '1;
    res_o = '0;
    res_o.status = emit_err ? err_st : xifd_pkg::ST_OK;
    res_o.length = cnt_n;
    res_o.rex = rex_q;
    res_o.opcode_map = map_q;
    if (emit_err) begin
      res_o.opcode = err_opc;
      if (err_st == xifd_pkg::ST_BAD_GRP) res_o.modrm = byte_i;
    end else begin
      res_o.opcode = opc_d;
      res_o.mnemonic_id = id_d;
      res_o.operand_form = form_d;
      res_o.modrm = modrm_d;
      res_o.sib = sib_d;
      res_o.displacement = disp_f;
      res_o.immediate = (phase_q == xifd_pkg::PH_IMM) ? imm_f : 64'd0;
    end
    res_o.last = 1'b1;
    res_o.emit = 1'b1;
    emit_o = valid_i & (emit_ok | emit_err);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xifd_pkg::PH_FIRST;
      rex_q <= '0; opc_q <= '0; map_q <= '0; id_q <= '0; form_q <= '0;
      kind_q <= xifd_pkg::KIND_NONE; imm_sz_q <= '0; modrm_q <= '0; sib_q <= '0;
      disp_q <= '0; imm_q <= '0; dsz_q <= '0; left_q <= '0; cnt_q <= '0; pos_q <= '0;
    end else if (emit_o) begin
      phase_q <= xifd_pkg::PH_FIRST;
      rex_q <= '0; opc_q <= '0; map_q <= '0; id_q <= '0; form_q <= '0;
      kind_q <= xifd_pkg::KIND_NONE; imm_sz_q <= '0; modrm_q <= '0; sib_q <= '0;
      disp_q <= '0; imm_q <= '0; dsz_q <= '0; left_q <= '0; cnt_q <= '0; pos_q <= '0;
    end else begin
      phase_q <= phase_d; rex_q <= rex_d; opc_q <= opc_d; map_q <= map_d; id_q <= id_d;
      form_q <= form_d; kind_q <= kind_d; imm_sz_q <= imm_sz_d; modrm_q <= modrm_d;
      sib_q <= sib_d; disp_q <= disp_d; imm_q <= imm_d; dsz_q <= dsz_d;
      left_q <= left_d; cnt_q <= cnt_d; pos_q <= pos_d;
    end
  end

endmodule

// File: hdl/xifd_fifo.sv
module xifd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  xifd_pkg::result_t wdata_i,
  input  logic              rd_i,
  output xifd_pkg::result_t rdata_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  xifd_pkg::result_t mem_q [Depth];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d = wp_q; rp_d = rp_q; cnt_d = cnt_q;
    if (wr_i) wp_d = (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    if (rd_i) rp_d = (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    if (wr_i && !rd_i) cnt_d = cnt_q + 1'b1;
    else if (rd_i && !wr_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/x86_instruction_field_decoder_top.sv
// a result is registered into the queue when the last byte of its instruction is accepted
// throughput: one code byte per cycle while the queue is not full, set by the single-byte capture in the front part
// results wait in a small queue; push stalls (full) only when that queue is full
// reset: asynchronous active low, empties the queue and restarts at the first byte
module x86_instruction_field_decoder_top #(
  parameter int unsigned QDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  code_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [3:0]  length_o,
  output logic [4:0]  rex_o,
  output logic [1:0]  opcode_map_o,
  output logic [7:0]  opcode_o,
  output logic [5:0]  mnemonic_id_o,
  output logic [2:0]  operand_form_o,
  output logic [7:0]  modrm_o,
  output logic [7:0]  sib_o,
  output logic signed [31:0] displacement_o,
  output logic signed [63:0] immediate_o
);

  logic              acc, emit, q_full, rd;
  xifd_pkg::result_t fres, qres;

  assign acc  = push & ~q_full;
  assign full = q_full;
  assign rd   = pop & ~empty;

  xifd_front u_front (
    .clk_i, .rst_ni, .valid_i(acc), .byte_i(code_byte_i), .emit_o(emit), .res_o(fres)
  );

  xifd_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i, .rst_ni, .wr_i(emit), .wdata_i(fres), .rd_i(rd), .rdata_o(qres),
    .empty_o(empty), .full_o(q_full)
  );

  assign status_o       = qres.status;
  assign length_o       = qres.length;
  assign rex_o          = qres.rex;
  assign opcode_map_o   = qres.opcode_map;
  assign opcode_o       = qres.opcode;
  assign mnemonic_id_o  = qres.mnemonic_id;
  assign operand_form_o = qres.operand_form;
  assign modrm_o        = qres.modrm;
  assign sib_o          = qres.sib;
  assign displacement_o = qres.displacement;
  assign immediate_o    = qres.immediate;

  a_emit_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> acc) else $error("result without byte");
  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !emit) else $error("queue overflow");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o != 2'd3)) else $error("bad status");

endmodule
